/* sv/neuron_backprop_momentum_unit_macros.svh */
// Assertion macros for the neuron back-propagation unit.
// Used by the RTL files that carry concurrent checks; no other dependencies.
`ifndef NEURON_BACKPROP_MOMENTUM_UNIT_MACROS_SVH
`define NEURON_BACKPROP_MOMENTUM_UNIT_MACROS_SVH

`ifndef SYNTH

`define NBM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

`define NBM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`else

`define NBM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define NBM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* sv/nbm_pkg.sv */
// Shared types, codes, widths and the tanh table for the neuron unit.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package nbm_pkg;

	localparam int MAX_INPUTS   = 64;
	localparam int TANH_ENTRIES = 1024;

	localparam int CMD_W    = 3;
	localparam int IDX_W    = 6;
	localparam int VAL_W    = 16;
	localparam int CFG_W    = 12;
	localparam int KIND_W   = 2;
	localparam int ACC_W    = 40;
	localparam int MA_W     = 29;
	localparam int MB_W     = 20;
	localparam int PROD_W   = MA_W + MB_W;
	localparam int ADDR_W   = $clog2(MAX_INPUTS);
	localparam int TIDX_W   = $clog2(TANH_ENTRIES);
	localparam int TANH_SHIFT = 15 - TIDX_W;
	localparam int TAB_W    = 13;

	localparam logic [CFG_W-1:0] LEARN_RATE_RST = 12'd614;
	localparam logic [CFG_W-1:0] MOMENTUM_RST   = 12'd2048;

	localparam logic CFG_LEARN_RATE = 1'b0;
	localparam logic CFG_MOMENTUM   = 1'b1;

	typedef enum logic [CMD_W-1:0] {
		CMD_FWD      = 3'd0,
		CMD_OUT_GRAD = 3'd1,
		CMD_HID_GRAD = 3'd2,
		CMD_UPDATE   = 3'd3,
		CMD_LOAD     = 3'd4,
		CMD_SET_OUT  = 3'd5
	} nbm_cmd_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_ACT    = 2'd0,
		KIND_GRAD   = 2'd1,
		KIND_WEIGHT = 2'd2
	} nbm_kind_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_FWD_MUL,
		S_FWD_ACC,
		S_FWD_TANH,
		S_FWD_ACT,
		S_OG_SQ,
		S_OG_DER,
		S_OG_MUL,
		S_HG_MUL,
		S_HG_ACC,
		S_HG_SQ,
		S_HG_DER,
		S_HG_MUL2,
		S_GRAD_OUT,
		S_UPD_MOM,
		S_UPD_MUL1,
		S_UPD_MUL2,
		S_UPD_SUM,
		S_UPD_WB,
		S_LOAD,
		S_SET_ACT
	} nbm_state_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_MUL_VW,
		OP_ACC_ADD,
		OP_TANH,
		OP_ACT_OUT,
		OP_SQ,
		OP_SQ_DOW,
		OP_DER,
		OP_MUL_VD,
		OP_MUL_VL,
		OP_MUL_DD,
		OP_GRAD_OUT,
		OP_MOM,
		OP_MUL_EV,
		OP_MUL_PG,
		OP_UPD_SUM,
		OP_UPD_WB,
		OP_LOAD,
		OP_SET_ACT
	} nbm_op_t;

	typedef struct packed {
		logic    capture;
		nbm_op_t op;
	} nbm_ctl_t;

	typedef struct packed {
		logic last;
	} nbm_stat_t;

	typedef logic [TAB_W-1:0] tanh_tab_t [TANH_ENTRIES];

	localparam logic [63:0] Q30_ONE   = 64'd1 << 30;
	localparam logic [63:0] TANH_STEP = (64'd16 << 30) / TANH_ENTRIES;

	// Restoring long division, used only while the table is built at elaboration.
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] dvs);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[63:0], num[b]};
			if (r >= {1'b0, dvs}) begin
				r    = r - {1'b0, dvs};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// Entry i holds tanh(8i/TANH_ENTRIES) in Q12, built as (1-e)/(1+e) with e = b^i in Q30.
	function automatic tanh_tab_t build_tanh();
		tanh_tab_t   tab;
		logic [63:0] h;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] e;
		logic [63:0] den;
		h    = TANH_STEP;
		term = Q30_ONE;
		sum  = Q30_ONE;
		e    = Q30_ONE;
		for (int n = 1; n <= 8; n++) begin
			term = udiv64((term * h) >> 30, 64'(n));
			if (n % 2 == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		for (int i = 0; i < TANH_ENTRIES; i++) begin
			den    = Q30_ONE + e;
			tab[i] = TAB_W'(udiv64((Q30_ONE - e) * 64'd8192 + den, den << 1));
			e      = (e * sum + (Q30_ONE >> 1)) >> 30;
		end
		return tab;
	endfunction

	localparam tanh_tab_t TANH_TAB = build_tanh();

endpackage

`default_nettype wire

/* sv/neuron_backprop_momentum_unit.sv */
// One tanh neuron with momentum descent; an item is accepted only in idle, and a new one waits
// until the last has run through its states (more of them on last for forward and hidden
// gradient), all sequenced around the shared multiplier.
// A result appears on strobe in the cycle after its last step and is not held; there is no stall.
// Reset clears the accumulator, activation, gradient, delta entries and restores
// learn_rate 614 and momentum 2048; weights are undefined until loaded.
`default_nettype none

module neuron_backprop_momentum_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic [nbm_pkg::CMD_W-1:0]        cmd,
	input  wire logic [nbm_pkg::IDX_W-1:0]        index,
	input  wire logic signed [nbm_pkg::VAL_W-1:0] value,
	input  wire logic signed [nbm_pkg::VAL_W-1:0] link_weight,
	input  wire logic                             last,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic                             cfg_index,
	input  wire logic [nbm_pkg::CFG_W-1:0]        cfg_data,
	output logic                                  strobe,
	output logic [nbm_pkg::KIND_W-1:0]            kind,
	output logic [nbm_pkg::IDX_W-1:0]             out_index,
	output logic signed [nbm_pkg::VAL_W-1:0]      out_value
);

	nbm_pkg::nbm_ctl_t  ctl;
	nbm_pkg::nbm_stat_t stat;

	assign cfg_ready = 1'b1;

	nbm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.stat   (stat),
		.ctl    (ctl),
		.busy   (busy)
	);

	nbm_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.stat        (stat),
		.index       (index),
		.value       (value),
		.link_weight (link_weight),
		.last        (last),
		.cfg_we      (cfg_valid & cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.strobe      (strobe),
		.kind        (kind),
		.out_index   (out_index),
		.out_value   (out_value)
	);

endmodule

`default_nettype wire

/* sv/nbm_ctrl.sv */
// Sequencing state machine of the neuron unit.
// Depends on nbm_pkg for the state, command and control types.
`default_nettype none

module nbm_ctrl (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [nbm_pkg::CMD_W-1:0]   cmd,
	input  wire nbm_pkg::nbm_stat_t          stat,
	output nbm_pkg::nbm_ctl_t                ctl,
	output logic                             busy
);

	nbm_pkg::nbm_state_t state_q;
	nbm_pkg::nbm_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nbm_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			nbm_pkg::S_IDLE: begin
				if (start) begin
					case (nbm_pkg::nbm_cmd_t'(cmd))
						nbm_pkg::CMD_FWD:      state_nxt = nbm_pkg::S_FWD_MUL;
						nbm_pkg::CMD_OUT_GRAD: state_nxt = nbm_pkg::S_OG_SQ;
						nbm_pkg::CMD_HID_GRAD: state_nxt = nbm_pkg::S_HG_MUL;
						nbm_pkg::CMD_UPDATE:   state_nxt = nbm_pkg::S_UPD_MOM;
						nbm_pkg::CMD_LOAD:     state_nxt = nbm_pkg::S_LOAD;
						nbm_pkg::CMD_SET_OUT:  state_nxt = nbm_pkg::S_SET_ACT;
						default:               state_nxt = nbm_pkg::S_IDLE;
					endcase
				end
			end
			nbm_pkg::S_FWD_MUL:  state_nxt = nbm_pkg::S_FWD_ACC;
			nbm_pkg::S_FWD_ACC:  state_nxt = stat.last ? nbm_pkg::S_FWD_TANH : nbm_pkg::S_IDLE;
			nbm_pkg::S_FWD_TANH: state_nxt = nbm_pkg::S_FWD_ACT;
			nbm_pkg::S_FWD_ACT:  state_nxt = nbm_pkg::S_IDLE;
			nbm_pkg::S_OG_SQ:    state_nxt = nbm_pkg::S_OG_DER;
			nbm_pkg::S_OG_DER:   state_nxt = nbm_pkg::S_OG_MUL;
			nbm_pkg::S_OG_MUL:   state_nxt = nbm_pkg::S_GRAD_OUT;
			nbm_pkg::S_HG_MUL:   state_nxt = nbm_pkg::S_HG_ACC;
			nbm_pkg::S_HG_ACC:   state_nxt = stat.last ? nbm_pkg::S_HG_SQ : nbm_pkg::S_IDLE;
			nbm_pkg::S_HG_SQ:    state_nxt = nbm_pkg::S_HG_DER;
			nbm_pkg::S_HG_DER:   state_nxt = nbm_pkg::S_HG_MUL2;
			nbm_pkg::S_HG_MUL2:  state_nxt = nbm_pkg::S_GRAD_OUT;
			nbm_pkg::S_GRAD_OUT: state_nxt = nbm_pkg::S_IDLE;
			nbm_pkg::S_UPD_MOM:  state_nxt = nbm_pkg::S_UPD_MUL1;
			nbm_pkg::S_UPD_MUL1: state_nxt = nbm_pkg::S_UPD_MUL2;
			nbm_pkg::S_UPD_MUL2: state_nxt = nbm_pkg::S_UPD_SUM;
			nbm_pkg::S_UPD_SUM:  state_nxt = nbm_pkg::S_UPD_WB;
			nbm_pkg::S_UPD_WB:   state_nxt = nbm_pkg::S_IDLE;
			nbm_pkg::S_LOAD:     state_nxt = nbm_pkg::S_IDLE;
			nbm_pkg::S_SET_ACT:  state_nxt = nbm_pkg::S_IDLE;
			default:             state_nxt = nbm_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ctl.capture = 1'b0;
		ctl.op      = nbm_pkg::OP_NONE;
		busy        = 1'b1;
		case (state_q)
			nbm_pkg::S_IDLE: begin
				busy        = 1'b0;
				ctl.capture = start;
			end
			nbm_pkg::S_FWD_MUL:  ctl.op = nbm_pkg::OP_MUL_VW;
			nbm_pkg::S_FWD_ACC:  ctl.op = nbm_pkg::OP_ACC_ADD;
			nbm_pkg::S_FWD_TANH: ctl.op = nbm_pkg::OP_TANH;
			nbm_pkg::S_FWD_ACT:  ctl.op = nbm_pkg::OP_ACT_OUT;
			nbm_pkg::S_OG_SQ:    ctl.op = nbm_pkg::OP_SQ;
			nbm_pkg::S_OG_DER:   ctl.op = nbm_pkg::OP_DER;
			nbm_pkg::S_OG_MUL:   ctl.op = nbm_pkg::OP_MUL_VD;
			nbm_pkg::S_HG_MUL:   ctl.op = nbm_pkg::OP_MUL_VL;
			nbm_pkg::S_HG_ACC:   ctl.op = nbm_pkg::OP_ACC_ADD;
			nbm_pkg::S_HG_SQ:    ctl.op = nbm_pkg::OP_SQ_DOW;
			nbm_pkg::S_HG_DER:   ctl.op = nbm_pkg::OP_DER;
			nbm_pkg::S_HG_MUL2:  ctl.op = nbm_pkg::OP_MUL_DD;
			nbm_pkg::S_GRAD_OUT: ctl.op = nbm_pkg::OP_GRAD_OUT;
			nbm_pkg::S_UPD_MOM:  ctl.op = nbm_pkg::OP_MOM;
			nbm_pkg::S_UPD_MUL1: ctl.op = nbm_pkg::OP_MUL_EV;
			nbm_pkg::S_UPD_MUL2: ctl.op = nbm_pkg::OP_MUL_PG;
			nbm_pkg::S_UPD_SUM:  ctl.op = nbm_pkg::OP_UPD_SUM;
			nbm_pkg::S_UPD_WB:   ctl.op = nbm_pkg::OP_UPD_WB;
			nbm_pkg::S_LOAD:     ctl.op = nbm_pkg::OP_LOAD;
			nbm_pkg::S_SET_ACT:  ctl.op = nbm_pkg::OP_SET_ACT;
			default:             ctl.op = nbm_pkg::OP_NONE;
		endcase
	end

endmodule

`default_nettype wire

/* sv/nbm_datapath.sv */
// Datapath of the neuron unit: shared multiplier, accumulator, weight and delta memories,
// tanh table and result register. Depends on nbm_pkg and the assertion macro header.
`default_nettype none
`include "neuron_backprop_momentum_unit_macros.svh"

module nbm_datapath (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire nbm_pkg::nbm_ctl_t              ctl,
	output nbm_pkg::nbm_stat_t                  stat,
	input  wire logic [nbm_pkg::IDX_W-1:0]      index,
	input  wire logic signed [nbm_pkg::VAL_W-1:0] value,
	input  wire logic signed [nbm_pkg::VAL_W-1:0] link_weight,
	input  wire logic                           last,
	input  wire logic                           cfg_we,
	input  wire logic                           cfg_index,
	input  wire logic [nbm_pkg::CFG_W-1:0]      cfg_data,
	output logic                                strobe,
	output logic [nbm_pkg::KIND_W-1:0]          kind,
	output logic [nbm_pkg::IDX_W-1:0]           out_index,
	output logic signed [nbm_pkg::VAL_W-1:0]    out_value
);

	localparam int AW    = nbm_pkg::ADDR_W;
	localparam int VW    = nbm_pkg::VAL_W;
	localparam int ACCW  = nbm_pkg::ACC_W;
	localparam int MAW   = nbm_pkg::MA_W;
	localparam int MBW   = nbm_pkg::MB_W;
	localparam int PW    = nbm_pkg::PROD_W;
	localparam int TW    = nbm_pkg::TIDX_W;
	localparam int TBW   = nbm_pkg::TAB_W;

	function automatic logic signed [VW-1:0] sat16(input logic signed [49:0] x);
		logic signed [VW-1:0] r;
		if (x > 50'sd32767) begin
			r = 16'sh7fff;
		end else if (x < -50'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = x[VW-1:0];
		end
		return r;
	endfunction

	logic signed [VW-1:0]   wmem [nbm_pkg::MAX_INPUTS];
	logic signed [VW-1:0]   dmem [nbm_pkg::MAX_INPUTS];
	logic [nbm_pkg::MAX_INPUTS-1:0] dvalid_q;

	logic signed [VW-1:0]   val_q;
	logic signed [VW-1:0]   link_q;
	logic [nbm_pkg::IDX_W-1:0] idx_q;
	logic                   last_q;
	logic                   ok_q;
	logic signed [VW-1:0]   w_rd_q;
	logic signed [VW-1:0]   d_rd_q;
	logic                   dv_rd_q;
	logic signed [ACCW-1:0] acc_q;
	logic signed [VW-1:0]   act_q;
	logic signed [VW-1:0]   grad_q;
	logic signed [PW-1:0]   prod_q;
	logic signed [MAW-1:0]  mom_q;
	logic signed [MAW-1:0]  dow_q;
	logic signed [MBW-1:0]  d_q;
	logic signed [VW-1:0]   nd_q;
	logic [TBW-1:0]         tab_q;
	logic                   neg_q;
	logic                   big_q;
	logic [nbm_pkg::CFG_W-1:0] eta_q;
	logic [nbm_pkg::CFG_W-1:0] alpha_q;
	logic                   strobe_q;
	nbm_pkg::nbm_kind_t     kind_q;
	logic [nbm_pkg::IDX_W-1:0] oidx_q;
	logic signed [VW-1:0]   oval_q;

	logic signed [MAW-1:0]  mul_a;
	logic signed [MBW-1:0]  mul_b;
	logic signed [PW-1:0]   mul_p;
	logic signed [31:0]     prod32;
	logic signed [ACCW:0]   acc_sum;
	logic signed [ACCW-1:0] acc_next;
	logic signed [ACCW:0]   acc_rnd;
	logic signed [MAW-1:0]  s_rnd;
	logic [MAW-1:0]         mag;
	logic [MAW-1:0]         tfull;
	logic                   tbig;
	logic [TW-1:0]          tidx;
	logic signed [32:0]     sq_rnd;
	logic signed [20:0]     d_full;
	logic signed [49:0]     g_rnd;
	logic signed [46:0]     p_upd;
	logic signed [VW:0]     w_sum;
	logic signed [VW-1:0]   w_new;
	logic signed [VW-1:0]   act_mag;
	logic signed [VW-1:0]   act_new;
	logic signed [VW:0]     vdiff;
	logic signed [VW-1:0]   delta_cur;
	logic [AW-1:0]          waddr;

	assign waddr     = AW'(idx_q);
	assign prod32    = prod_q[31:0];
	assign delta_cur = dv_rd_q ? d_rd_q : '0;
	assign vdiff     = (VW+1)'(val_q) - (VW+1)'(act_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (ctl.op)
			nbm_pkg::OP_MUL_VW: begin
				mul_a = ok_q ? MAW'(val_q) : '0;
				mul_b = MBW'(w_rd_q);
			end
			nbm_pkg::OP_SQ, nbm_pkg::OP_SQ_DOW: begin
				mul_a = MAW'(act_q);
				mul_b = MBW'(act_q);
			end
			nbm_pkg::OP_MUL_VD: begin
				mul_a = MAW'(vdiff);
				mul_b = d_q;
			end
			nbm_pkg::OP_MUL_VL: begin
				mul_a = MAW'(val_q);
				mul_b = MBW'(link_q);
			end
			nbm_pkg::OP_MUL_DD: begin
				mul_a = dow_q;
				mul_b = d_q;
			end
			nbm_pkg::OP_MOM: begin
				mul_a = MAW'(delta_cur);
				mul_b = $signed(MBW'(alpha_q));
			end
			nbm_pkg::OP_MUL_EV: begin
				mul_a = MAW'(val_q);
				mul_b = $signed(MBW'(eta_q));
			end
			nbm_pkg::OP_MUL_PG: begin
				mul_a = $signed(prod_q[MAW-1:0]);
				mul_b = MBW'(grad_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = PW'(mul_a) * PW'(mul_b);

	always_comb begin
		acc_sum = (ACCW+1)'(acc_q) + (ACCW+1)'(prod32);
		if (acc_sum[ACCW] != acc_sum[ACCW-1]) begin
			acc_next = acc_sum[ACCW] ? {1'b1, {(ACCW-1){1'b0}}} : {1'b0, {(ACCW-1){1'b1}}};
		end else begin
			acc_next = acc_sum[ACCW-1:0];
		end
	end

	assign acc_rnd = (ACCW+1)'(acc_q) + (ACCW+1)'(2048);
	assign s_rnd   = acc_rnd[ACCW:12];
	assign mag     = s_rnd[MAW-1] ? MAW'(-s_rnd) : MAW'(s_rnd);
	assign tfull   = mag >> nbm_pkg::TANH_SHIFT;
	assign tbig    = tfull >= MAW'(nbm_pkg::TANH_ENTRIES);
	assign tidx    = tfull[TW-1:0];

	assign sq_rnd  = 33'(prod32) + 33'sd2048;
	assign d_full  = 21'sd4096 - $signed(sq_rnd[32:12]);

	assign g_rnd   = 50'(prod_q) + 50'sd2048;
	assign p_upd   = 47'($signed(prod_q[44:0])) + (47'(mom_q) <<< 12) + 47'sd8388608;
	assign w_sum   = (VW+1)'(w_rd_q) + (VW+1)'(nd_q);
	assign w_new   = sat16(50'(w_sum));

	assign act_mag = big_q ? 16'sd4096 : $signed(VW'(tab_q));
	assign act_new = neg_q ? -act_mag : act_mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			act_q    <= '0;
			grad_q   <= '0;
			eta_q    <= nbm_pkg::LEARN_RATE_RST;
			alpha_q  <= nbm_pkg::MOMENTUM_RST;
			strobe_q <= 1'b0;
			dvalid_q <= '0;
		end else begin
			strobe_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					nbm_pkg::CFG_LEARN_RATE: eta_q   <= cfg_data;
					nbm_pkg::CFG_MOMENTUM:   alpha_q <= cfg_data;
					default: ;
				endcase
			end
			case (ctl.op)
				nbm_pkg::OP_ACC_ADD: acc_q <= acc_next;
				nbm_pkg::OP_TANH:    acc_q <= '0;
				nbm_pkg::OP_SQ_DOW:  acc_q <= '0;
				nbm_pkg::OP_ACT_OUT: begin
					act_q    <= act_new;
					strobe_q <= 1'b1;
				end
				nbm_pkg::OP_GRAD_OUT: begin
					grad_q   <= sat16(g_rnd >>> 12);
					strobe_q <= 1'b1;
				end
				nbm_pkg::OP_UPD_WB: begin
					if (ok_q) begin
						dvalid_q[waddr] <= 1'b1;
						strobe_q        <= 1'b1;
					end
				end
				nbm_pkg::OP_LOAD: begin
					if (ok_q) begin
						dvalid_q[waddr] <= 1'b0;
					end
				end
				nbm_pkg::OP_SET_ACT: act_q <= val_q;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			val_q   <= value;
			link_q  <= link_weight;
			idx_q   <= index;
			last_q  <= last;
			ok_q    <= (32'(index) < 32'(nbm_pkg::MAX_INPUTS));
			w_rd_q  <= wmem[AW'(index)];
			d_rd_q  <= dmem[AW'(index)];
			dv_rd_q <= dvalid_q[AW'(index)];
		end
		case (ctl.op)
			nbm_pkg::OP_MUL_VW, nbm_pkg::OP_SQ, nbm_pkg::OP_MUL_VD, nbm_pkg::OP_MUL_VL,
			nbm_pkg::OP_MUL_DD, nbm_pkg::OP_MUL_EV, nbm_pkg::OP_MUL_PG: begin
				prod_q <= mul_p;
			end
			nbm_pkg::OP_SQ_DOW: begin
				prod_q <= mul_p;
				dow_q  <= s_rnd;
			end
			nbm_pkg::OP_MOM: mom_q <= mul_p[MAW-1:0];
			nbm_pkg::OP_TANH: begin
				tab_q <= nbm_pkg::TANH_TAB[tidx];
				big_q <= tbig;
				neg_q <= s_rnd[MAW-1];
			end
			nbm_pkg::OP_DER: d_q <= d_full[MBW-1:0];
			nbm_pkg::OP_ACT_OUT: begin
				kind_q <= nbm_pkg::KIND_ACT;
				oidx_q <= '0;
				oval_q <= act_new;
			end
			nbm_pkg::OP_GRAD_OUT: begin
				kind_q <= nbm_pkg::KIND_GRAD;
				oidx_q <= '0;
				oval_q <= sat16(g_rnd >>> 12);
			end
			nbm_pkg::OP_UPD_SUM: nd_q <= sat16(50'(p_upd >>> 24));
			nbm_pkg::OP_UPD_WB: begin
				if (ok_q) begin
					wmem[waddr] <= w_new;
					dmem[waddr] <= nd_q;
				end
				kind_q <= nbm_pkg::KIND_WEIGHT;
				oidx_q <= idx_q;
				oval_q <= w_new;
			end
			nbm_pkg::OP_LOAD: begin
				if (ok_q) begin
					wmem[waddr] <= val_q;
				end
			end
			default: ;
		endcase
	end

	assign stat.last = last_q;
	assign strobe    = strobe_q;
	assign kind      = kind_q;
	assign out_index = oidx_q;
	assign out_value = oval_q;

	`NBM_ASSERT_NEXT(a_grad_emit, clk, arst_n, ctl.op == nbm_pkg::OP_GRAD_OUT,
		strobe_q && kind_q == nbm_pkg::KIND_GRAD)
	`NBM_ASSERT_NEXT(a_acc_clear, clk, arst_n,
		ctl.op == nbm_pkg::OP_TANH || ctl.op == nbm_pkg::OP_SQ_DOW, acc_q == '0)
	`NBM_ASSERT_IMP(a_idx_zero, clk, arst_n, strobe_q && kind_q != nbm_pkg::KIND_WEIGHT,
		oidx_q == '0)

endmodule

`default_nettype wire
